### design/ssp_pkg.sv
`timescale 1ns / 1ps
// Shared types, code-unit constants and helper functions for the scanf specifier parser.
package ssp_pkg;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_ARGNUM,
        PH_FLAGS,
        PH_PAD,
        PH_WIDTH,
        PH_AFTER_L,
        PH_SPEC
    } ssp_phase_t;

    localparam logic [15:0] U_STAR   = 16'h002A;
    localparam logic [15:0] U_PAREN  = 16'h0028;
    localparam logic [15:0] U_DOLLAR = 16'h0024;
    localparam logic [15:0] U_ZERO   = 16'h0030;
    localparam logic [15:0] U_NINE   = 16'h0039;
    localparam logic [15:0] U_H      = 16'h0068;
    localparam logic [15:0] U_LL     = 16'h006C;
    localparam logic [15:0] U_BIGL   = 16'h004C;
    localparam logic [15:0] U_SPACE  = 16'h0020;

    localparam logic [2:0] SIZE_NONE    = 3'd0;
    localparam logic [2:0] SIZE_SHORT   = 3'd1;
    localparam logic [2:0] SIZE_LONG    = 3'd2;
    localparam logic [2:0] SIZE_LLONG   = 3'd3;
    localparam logic [2:0] SIZE_LDOUBLE = 3'd4;

    localparam logic [7:0] LENGTH_MAX = 8'hFF;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        first_unit;
    } ssp_in_t;

    typedef struct packed {
        logic        arg_present;
        logic [15:0] arg_position;
        logic        skip_assign;
        logic [15:0] pad_char;
        logic        width_present;
        logic [15:0] field_width;
        logic [2:0]  size_mod;
        logic [15:0] spec_char;
        logic [7:0]  spec_length;
        logic        number_overflow;
    } ssp_out_t;

    typedef struct packed {
        ssp_phase_t  phase;
        logic [15:0] number_acc;
        logic        arg_present;
        logic [15:0] arg_value;
        logic        skip_flag;
        logic [15:0] pad;
        logic [2:0]  pad_digit_count;
        logic        width_present;
        logic [15:0] width_value;
        logic [2:0]  size;
        logic [7:0]  length_count;
        logic        overflow;
    } ssp_state_t;

    function automatic ssp_state_t ssp_clear();
        ssp_state_t s;
        s                 = '0;
        s.phase           = PH_IDLE;
        s.pad             = U_SPACE;
        s.size            = SIZE_NONE;
        return s;
    endfunction

    function automatic logic is_digit(input logic [15:0] c);
        return (c >= U_ZERO) && (c <= U_NINE);
    endfunction

    // Non-hex units count as zero.
    function automatic logic [3:0] hex_value(input logic [15:0] c);
        logic [15:0] d;
        d = '0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            d = c - 16'h0030;
        end else if (c >= 16'h0041 && c <= 16'h0046) begin
            d = c - 16'h0037;
        end else if (c >= 16'h0061 && c <= 16'h0066) begin
            d = c - 16'h0057;
        end
        return d[3:0];
    endfunction

endpackage

### design/scanf_spec_parser.sv
`timescale 1ns / 1ps
// Top level of the scanf conversion specifier parser with its input and result registers.
//
//  Channel   Direction  Handshake          Word
//  s_        in         s_valid / s_ready  ssp_in_t  : code_unit, first_unit
//  m_        out        m_valid / m_ready  ssp_out_t : one record per finished specifier
//
// One code unit is taken per cycle while a waiting result does not hold the input register;
// a word sits in the input register while the parser state and the result register are
// updated from it, so the result of a specifier letter passes from the input register
// into the result register, where it waits until the consumer takes it.
// Reset (aresetn low at a clock edge) empties both registers and returns the parser to
// idle with default pad, no width, no position and a zero length count.
// A result waiting in the output register blocks the input register only; the input
// register still takes a new word when its current word moves on in the same cycle.
module scanf_spec_parser #(
    parameter int NUMBER_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ssp_pkg::ssp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ssp_pkg::ssp_out_t m_data
);
    import ssp_pkg::*;

    // Input register: holds one accepted word until the parser consumes it.
    logic       in_valid_reg, in_valid_next;
    ssp_in_t    in_word_reg;

    // Parser state carried from one code unit to the next.
    ssp_state_t state_reg, state_next;

    // Result register: holds a finished record until the consumer takes it.
    logic       out_valid_reg, out_valid_next;
    ssp_out_t   out_word_reg;

    ssp_state_t step_state;
    logic       step_valid;
    ssp_out_t   step_word;
    logic       advance;

    ssp_step #(
        .NUMBER_BITS(NUMBER_BITS)
    ) u_step (
        .cur_state(state_reg),
        .in_word  (in_word_reg),
        .nxt_state(step_state),
        .res_valid(step_valid),
        .res_word (step_word)
    );

    // The held word is processed when the result register is free or being emptied,
    // so a record is never overwritten before it has been taken.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        state_next = advance ? step_state : state_reg;

        if (advance) begin
            out_valid_next = step_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            state_reg     <= ssp_clear();
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
        if (advance && step_valid) begin
            out_word_reg <= step_word;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    // A finished specifier always returns the parser to idle.
    a_idle_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step_valid |=> state_reg.phase == PH_IDLE)
        else $error("parser not idle after a result");

    // A percent unit restarts the count at one and opens a new specifier.
    a_first_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_word_reg.first_unit
        |=> state_reg.length_count == 8'd1 && state_reg.phase == PH_START)
        else $error("first unit did not restart the specifier");

    // Units outside a specifier never make a record.
    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && state_reg.phase == PH_IDLE && !in_word_reg.first_unit |-> !step_valid)
        else $error("record produced while idle");

    // Every record covers at least the percent sign and the letter and has a known size code.
    a_min_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.spec_length >= 8'd2 && m_data.size_mod <= SIZE_LDOUBLE)
        else $error("record with impossible length or size code");

    // The result register is never loaded over a record that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_word_reg))
        else $error("pending record was overwritten");

endmodule

### design/ssp_step.sv
`timescale 1ns / 1ps
// Next-state and result logic for one code unit of the specifier parser.
module ssp_step #(
    parameter int NUMBER_BITS = 16
) (
    input  ssp_pkg::ssp_state_t cur_state,
    input  ssp_pkg::ssp_in_t    in_word,
    output ssp_pkg::ssp_state_t nxt_state,
    output logic                res_valid,
    output ssp_pkg::ssp_out_t   res_word
);
    import ssp_pkg::*;

    localparam int          LIM_INT = (NUMBER_BITS >= 16) ? 65535 : (1 << NUMBER_BITS) - 1;
    localparam logic [19:0] LIMIT   = 20'(LIM_INT);

    // Multiply by ten as two shifts and add the digit; saturate at the limit.
    function automatic ssp_state_t acc_digit(input ssp_state_t s, input logic [15:0] c);
        ssp_state_t r;
        logic [19:0] v;
        r = s;
        v = ({4'b0, s.number_acc} << 3) + ({4'b0, s.number_acc} << 1) + {16'b0, c[3:0]};
        if (v > LIMIT) begin
            v          = LIMIT;
            r.overflow = 1'b1;
        end
        r.number_acc = v[15:0];
        return r;
    endfunction

    function automatic ssp_state_t do_mods(input ssp_state_t s, input logic [15:0] c,
                                           output logic em);
        ssp_state_t r;
        r  = s;
        em = 1'b0;
        if (c == U_H) begin
            r.size  = SIZE_SHORT;
            r.phase = PH_SPEC;
        end else if (c == U_LL) begin
            r.phase = PH_AFTER_L;
        end else if (c == U_BIGL) begin
            r.size  = SIZE_LDOUBLE;
            r.phase = PH_SPEC;
        end else begin
            em = 1'b1;
        end
        return r;
    endfunction

    function automatic ssp_state_t do_flags(input ssp_state_t s, input logic [15:0] c,
                                            output logic em);
        ssp_state_t r;
        r  = s;
        em = 1'b0;
        if (c == U_STAR) begin
            r.skip_flag = 1'b1;
            r.phase     = PH_FLAGS;
        end else if (c == U_PAREN) begin
            r.pad             = '0;
            r.pad_digit_count = '0;
            r.phase           = PH_PAD;
        end else if (is_digit(c)) begin
            r.number_acc = '0;
            r            = acc_digit(r, c);
            r.phase      = PH_WIDTH;
        end else begin
            r = do_mods(r, c, em);
        end
        return r;
    endfunction

    ssp_state_t  s;
    logic        em;
    logic [15:0] c;

    always_comb begin
        s  = cur_state;
        em = 1'b0;
        c  = in_word.code_unit;
        if (in_word.first_unit) begin
            s              = ssp_clear();
            s.length_count = 8'd1;
            s.phase        = PH_START;
        end else if (s.phase != PH_IDLE) begin
            if (s.length_count != LENGTH_MAX) begin
                s.length_count = s.length_count + 8'd1;
            end
            unique case (s.phase)
                PH_START: begin
                    if (is_digit(c)) begin
                        s.number_acc = '0;
                        s            = acc_digit(s, c);
                        s.phase      = PH_ARGNUM;
                    end else begin
                        s = do_flags(s, c, em);
                    end
                end
                PH_ARGNUM: begin
                    if (is_digit(c)) begin
                        s = acc_digit(s, c);
                    end else if (c == U_DOLLAR) begin
                        s.arg_present = 1'b1;
                        s.arg_value   = s.number_acc;
                        s.number_acc  = '0;
                        s.phase       = PH_FLAGS;
                    end else begin
                        // Digits without a dollar sign were the width.
                        s.width_present = 1'b1;
                        s.width_value   = s.number_acc;
                        s               = do_mods(s, c, em);
                    end
                end
                PH_FLAGS: begin
                    s = do_flags(s, c, em);
                end
                PH_PAD: begin
                    if (s.pad_digit_count < 3'd4) begin
                        s.pad             = {s.pad[11:0], hex_value(c)};
                        s.pad_digit_count = s.pad_digit_count + 3'd1;
                    end else begin
                        // The unit after the four pad digits is dropped.
                        s.pad_digit_count = '0;
                        s.phase           = PH_FLAGS;
                    end
                end
                PH_WIDTH: begin
                    if (is_digit(c)) begin
                        s = acc_digit(s, c);
                    end else begin
                        s.width_present = 1'b1;
                        s.width_value   = s.number_acc;
                        s               = do_mods(s, c, em);
                    end
                end
                PH_AFTER_L: begin
                    if (c == U_LL) begin
                        s.size  = SIZE_LLONG;
                        s.phase = PH_SPEC;
                    end else begin
                        s.size = SIZE_LONG;
                        em     = 1'b1;
                    end
                end
                PH_SPEC: begin
                    em = 1'b1;
                end
                default: begin
                    s = ssp_clear();
                end
            endcase
        end

        res_word.arg_present     = s.arg_present;
        res_word.arg_position    = s.arg_present ? s.arg_value : '0;
        res_word.skip_assign     = s.skip_flag;
        res_word.pad_char        = s.pad;
        res_word.width_present   = s.width_present;
        res_word.field_width     = s.width_present ? s.width_value : '0;
        res_word.size_mod        = s.size;
        res_word.spec_char       = c;
        res_word.spec_length     = s.length_count;
        res_word.number_overflow = s.overflow;

        res_valid = em;
        nxt_state = em ? ssp_clear() : s;
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the scanf specifier parser: a directed opening, then random specifiers.
module tb_top;
    import ssp_pkg::*;

    // The parser is built with its default number width, so numbers saturate at 0xFFFF.
    localparam int          NUM_BITS     = 16;
    localparam logic [31:0] NUM_MAX      = (NUM_BITS >= 16) ? 32'h0000_FFFF
                                                            : (32'd1 << NUM_BITS) - 32'd1;
    localparam int          ITEM_TARGET  = 550;
    localparam int          STEADY_TAIL  = 80;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 20;

    typedef struct {
        ssp_in_t  word;
        bit       has_rec;
        ssp_out_t rec;
    } opening_row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    ssp_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    ssp_out_t m_data;

    // Records the parser still owes us, oldest first.
    ssp_out_t     expected_records[$];
    opening_row_t opening_rows[$];
    int           mismatches   = 0;
    int           words_sent   = 0;
    int           stuck_cycles = 0;
    bit           hold_request = 1'b0;
    bit           steady_tail  = 1'b0;
    string        spec_letters = "diouxXfeEgGcsSpn";
    string        hex_chars    = "0123456789abcdefABCDEF";

    // Shadow copy of the parser state, advanced once per accepted word.
    ssp_phase_t  spec_phase;
    logic [15:0] num_acc;
    logic        arg_seen;
    logic [15:0] arg_pos;
    logic        skip_seen;
    logic [15:0] pad_unit;
    logic [2:0]  pad_digits;
    logic        width_seen;
    logic [15:0] width_val;
    logic [2:0]  size_code;
    logic [7:0]  spec_length;
    logic        spec_overflow;

    scanf_spec_parser #(
        .NUMBER_BITS(NUM_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Specifier predictor
    // ------------------------------------------------------------------

    function automatic logic is_decimal(input logic [15:0] c);
        return (c >= U_ZERO) && (c <= U_NINE);
    endfunction

    // Hex digits of either case give their value; anything else pads in a zero nibble.
    function automatic logic [3:0] pad_nibble(input logic [15:0] c);
        if (c >= 16'h0030 && c <= 16'h0039) return c[3:0];
        if ((c >= 16'h0041 && c <= 16'h0046) || (c >= 16'h0061 && c <= 16'h0066))
            return c[3:0] + 4'd9;
        return 4'd0;
    endfunction

    function automatic void clear_spec();
        spec_phase    = PH_IDLE;
        num_acc       = '0;
        arg_seen      = 1'b0;
        arg_pos       = '0;
        skip_seen     = 1'b0;
        pad_unit      = U_SPACE;
        pad_digits    = '0;
        width_seen    = 1'b0;
        width_val     = '0;
        size_code     = SIZE_NONE;
        spec_length   = '0;
        spec_overflow = 1'b0;
    endfunction

    // A digit that would carry the number past its limit pins it there and flags it.
    function automatic void add_digit(input logic [15:0] c);
        logic [31:0] v;
        v = {16'd0, num_acc} * 32'd10 + {16'd0, c - U_ZERO};
        if (v > NUM_MAX) begin
            v             = NUM_MAX;
            spec_overflow = 1'b1;
        end
        num_acc = v[15:0];
    endfunction

    function automatic ssp_out_t close_spec(input logic [15:0] c);
        ssp_out_t r;
        r.arg_present     = arg_seen;
        r.arg_position    = arg_seen ? arg_pos : 16'd0;
        r.skip_assign     = skip_seen;
        r.pad_char        = pad_unit;
        r.width_present   = width_seen;
        r.field_width     = width_seen ? width_val : 16'd0;
        r.size_mod        = size_code;
        r.spec_char       = c;
        r.spec_length     = spec_length;
        r.number_overflow = spec_overflow;
        clear_spec();
        return r;
    endfunction

    function automatic bit take_modifier(input logic [15:0] c);
        if (c == U_H) begin
            size_code  = SIZE_SHORT;
            spec_phase = PH_SPEC;
            return 1'b1;
        end
        if (c == U_LL) begin
            spec_phase = PH_AFTER_L;
            return 1'b1;
        end
        if (c == U_BIGL) begin
            size_code  = SIZE_LDOUBLE;
            spec_phase = PH_SPEC;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit take_flag(input logic [15:0] c);
        if (c == U_STAR) begin
            skip_seen  = 1'b1;
            spec_phase = PH_FLAGS;
            return 1'b1;
        end
        if (c == U_PAREN) begin
            pad_unit   = '0;
            pad_digits = '0;
            spec_phase = PH_PAD;
            return 1'b1;
        end
        if (is_decimal(c)) begin
            num_acc = '0;
            add_digit(c);
            spec_phase = PH_WIDTH;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the shadow state by one word; returns 1 with the record when a spec closes.
    function automatic bit parse_unit(input ssp_in_t w, output ssp_out_t rec);
        logic [15:0] c;
        c   = w.code_unit;
        rec = '0;
        // A marked percent always opens a fresh spec, dropping any partial one.
        if (w.first_unit) begin
            clear_spec();
            spec_length = 8'd1;
            spec_phase  = PH_START;
            return 1'b0;
        end
        if (spec_phase == PH_IDLE) return 1'b0;
        if (spec_length != LENGTH_MAX) spec_length++;
        case (spec_phase)
            PH_START, PH_FLAGS: begin
                // Leading digits may still turn out to be a position, so they go their own way.
                if (spec_phase == PH_START && is_decimal(c)) begin
                    num_acc = '0;
                    add_digit(c);
                    spec_phase = PH_ARGNUM;
                    return 1'b0;
                end
                if (take_flag(c) || take_modifier(c)) return 1'b0;
                rec = close_spec(c);
                return 1'b1;
            end
            PH_ARGNUM, PH_WIDTH: begin
                if (is_decimal(c)) begin
                    add_digit(c);
                    return 1'b0;
                end
                if (spec_phase == PH_ARGNUM && c == U_DOLLAR) begin
                    arg_seen   = 1'b1;
                    arg_pos    = num_acc;
                    num_acc    = '0;
                    spec_phase = PH_FLAGS;
                    return 1'b0;
                end
                // Digits without a dollar are the width; the unit after them is parsed on.
                width_seen = 1'b1;
                width_val  = num_acc;
                if (take_modifier(c)) return 1'b0;
                rec = close_spec(c);
                return 1'b1;
            end
            PH_PAD: begin
                // Four pad digits, then one unit that is swallowed.
                if (pad_digits < 3'd4) begin
                    pad_unit   = {pad_unit[11:0], pad_nibble(c)};
                    pad_digits = pad_digits + 3'd1;
                end else begin
                    pad_digits = '0;
                    spec_phase = PH_FLAGS;
                end
            end
            PH_AFTER_L: begin
                if (c == U_LL) begin
                    size_code  = SIZE_LLONG;
                    spec_phase = PH_SPEC;
                    return 1'b0;
                end
                size_code = SIZE_LONG;
                rec = close_spec(c);
                return 1'b1;
            end
            PH_SPEC: begin
                rec = close_spec(c);
                return 1'b1;
            end
            default: clear_spec();
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [15:0] e,
                                        input logic [15:0] a);
        if (e !== a) begin
            $display("%0t ns: %s expected %h, got %h", $time, name, e, a);
            mismatches++;
        end
    endfunction

    function automatic void check_record(input ssp_out_t e, input ssp_out_t a);
        check_field("arg_present", 16'(e.arg_present), 16'(a.arg_present));
        check_field("arg_position", e.arg_position, a.arg_position);
        check_field("skip_assign", 16'(e.skip_assign), 16'(a.skip_assign));
        check_field("pad_char", e.pad_char, a.pad_char);
        check_field("width_present", 16'(e.width_present), 16'(a.width_present));
        check_field("field_width", e.field_width, a.field_width);
        check_field("size_mod", 16'(e.size_mod), 16'(a.size_mod));
        check_field("spec_char", e.spec_char, a.spec_char);
        check_field("spec_length", 16'(e.spec_length), 16'(a.spec_length));
        check_field("number_overflow", 16'(e.number_overflow), 16'(a.number_overflow));
    endfunction

    // Every record word the parser hands over is matched against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_records.size() == 0) begin
                $display("%0t ns: record word with nothing expected, spec_char %h",
                         $time, m_data.spec_char);
                mismatches++;
            end else begin
                check_record(expected_records.pop_front(), m_data);
            end
        end
    end

    // The run is abandoned when no word moves on either side for too long. The longest
    // legal silence is the deliberate receiver hold, well under this limit.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Record receiver: random back-pressure bursts, one long hold on request,
    // and none at all in the closing stretch.
    // ------------------------------------------------------------------

    initial begin : record_sink
        int stall_left;
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_request = 1'b0;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!steady_tail && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 12);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Code unit sender
    // ------------------------------------------------------------------

    function automatic ssp_in_t make_word(input logic [15:0] c, input logic f);
        ssp_in_t w;
        w.code_unit  = c;
        w.first_unit = f;
        return w;
    endfunction

    function automatic ssp_out_t plain_record(input logic [15:0] spec, input logic [7:0] len);
        ssp_out_t r;
        r             = '0;
        r.pad_char    = U_SPACE;
        r.size_mod    = SIZE_NONE;
        r.spec_char   = spec;
        r.spec_length = len;
        return r;
    endfunction

    function automatic void add_unit(input logic [15:0] c, input bit has_rec,
                                     input ssp_out_t rec);
        opening_row_t row;
        row.word    = make_word(c, 1'b0);
        row.has_rec = has_rec;
        row.rec     = rec;
        opening_rows.push_back(row);
    endfunction

    // A percent in the text is sent as the marked opening unit.
    function automatic void add_text(input string s);
        opening_row_t row;
        for (int i = 0; i < s.len(); i++) begin
            row.word    = make_word({8'h00, s[i]}, s[i] == "%");
            row.has_rec = 1'b0;
            row.rec     = '0;
            opening_rows.push_back(row);
        end
    endfunction

    // Offers one word, holding it until taken, then books what it should cause.
    // A row with a typed record books that record in place of the predicted one.
    task automatic put_word(input ssp_in_t w, input bit counts, input bit has_rec,
                            input ssp_out_t rec);
        ssp_out_t predicted;
        int       gap;
        if (!steady_tail && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        if (parse_unit(w, predicted) && !has_rec) expected_records.push_back(predicted);
        if (has_rec) expected_records.push_back(rec);
        if (counts) words_sent++;
    endtask

    // Drops valid and waits until the parser has delivered everything it owes.
    task automatic drain_records();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge aclk);
    endtask

    task automatic push_text(ref ssp_in_t seq[$], input string s);
        for (int i = 0; i < s.len(); i++) seq.push_back(make_word({8'h00, s[i]}, 1'b0));
    endtask

    // Decimal numbers: short ones, the saturation edge from both sides, long overflowing
    // ones and leading zeros.
    task automatic add_number(ref ssp_in_t seq[$]);
        int digits;
        case ($urandom_range(0, 5))
            0: digits = $urandom_range(1, 2);
            1: digits = $urandom_range(1, 5);
            2: begin
                push_text(seq, "65535");
                return;
            end
            3: begin
                push_text(seq, "65536");
                return;
            end
            4: digits = $urandom_range(6, 9);
            default: begin
                push_text(seq, "000");
                digits = $urandom_range(1, 3);
            end
        endcase
        repeat (digits) seq.push_back(make_word(U_ZERO + 16'($urandom_range(0, 9)), 1'b0));
    endtask

    // One well-formed specifier with random content, now and then cut short or preceded
    // by stray units. A long flag run pushes the length count into saturation.
    task automatic send_random_spec(input bit long_flags);
        ssp_in_t seq[$];
        int      n;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4)) put_word(make_word(16'($urandom), 1'b0), 1'b0, 1'b0, '0);
        end
        seq.push_back(make_word(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0025, 1'b1));
        if ($urandom_range(0, 2) == 0) begin
            add_number(seq);
            seq.push_back(make_word(U_DOLLAR, 1'b0));
        end
        n = long_flags ? $urandom_range(255, 290) : $urandom_range(0, 2);
        repeat (n) begin
            if (!long_flags && $urandom_range(0, 2) == 0) begin
                seq.push_back(make_word(U_PAREN, 1'b0));
                repeat (4) begin
                    seq.push_back(make_word(($urandom_range(0, 3) == 0) ? 16'($urandom) :
                        {8'h00, hex_chars[$urandom_range(0, hex_chars.len() - 1)]}, 1'b0));
                end
                seq.push_back(make_word(16'($urandom), 1'b0));
            end else begin
                seq.push_back(make_word(U_STAR, 1'b0));
            end
        end
        if ($urandom_range(0, 1) == 0) add_number(seq);
        case ($urandom_range(0, 4))
            1: seq.push_back(make_word(U_H, 1'b0));
            2: seq.push_back(make_word(U_LL, 1'b0));
            3: begin
                seq.push_back(make_word(U_LL, 1'b0));
                seq.push_back(make_word(U_LL, 1'b0));
            end
            4: seq.push_back(make_word(U_BIGL, 1'b0));
            default: ;
        endcase
        seq.push_back(make_word(($urandom_range(0, 3) == 0) ? 16'($urandom) :
            {8'h00, spec_letters[$urandom_range(0, spec_letters.len() - 1)]}, 1'b0));
        if (!long_flags && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, seq.size() - 1);
            repeat (n) void'(seq.pop_back());
        end
        foreach (seq[i]) put_word(seq[i], 1'b1, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        ssp_out_t rec;
        int       spec_count;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        spec_count = 0;
        clear_spec();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // A stray unit while idle is dropped without a record.
        add_unit(16'hFFFF, 1'b0, '0);
        // Long double modifier with the highest possible specifier unit.
        add_text("%L");
        rec = plain_record(16'hFFFF, 8'd3);
        rec.size_mod = SIZE_LDOUBLE;
        add_unit(16'hFFFF, 1'b1, rec);
        // Position, skip, a pad with both hex cases and a non-hex digit, and short.
        add_text("%12$*(aF9Z)hd");
        // A spec cut off by a new percent, then an overflowing width with long long.
        add_text("%7%99999ll");
        rec = plain_record(16'h0078, 8'd9);
        rec.width_present   = 1'b1;
        rec.field_width     = 16'hFFFF;
        rec.size_mod        = SIZE_LLONG;
        rec.number_overflow = 1'b1;
        add_unit(16'h0078, 1'b1, rec);
        // A single l closed by a unit that is not a second l.
        add_text("%l0");
        foreach (opening_rows[i]) begin
            put_word(opening_rows[i].word, 1'b1, opening_rows[i].has_rec, opening_rows[i].rec);
        end

        while (words_sent < ITEM_TARGET) begin
            spec_count++;
            // The receiver stops for a long while and the sender keeps offering, so the
            // parser backs up into its input.
            if (spec_count == 5) hold_request = 1'b1;
            if (spec_count == 12) drain_records();
            if (words_sent > ITEM_TARGET - STEADY_TAIL) steady_tail = 1'b1;
            send_random_spec(spec_count == 20);
        end

        drain_records();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

### scanf_spec_parser.f
design/ssp_pkg.sv
design/ssp_step.sv
design/scanf_spec_parser.sv
test/tb_top.sv
